// ===== rtl/voice_volume_log_encoder_top_macros.svh =====
// assertion macros for the volume log encoder
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef VOICE_VOLUME_LOG_ENCODER_TOP_MACROS_SVH
`define VOICE_VOLUME_LOG_ENCODER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define VVLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define VVLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vvle_pkg.sv =====
// package for the volume log encoder: register indexes, widths, scaling constants
// no dependencies
`timescale 1ns / 1ps

package vvle_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MASTER_VOLUME    = 2'd0,
    CFG_USE_CHANNEL_MAIN = 2'd1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  // master volume squared after reset (60 * 60)
  localparam logic [13:0] MasterVolSqReset = 14'd3600;

  // floor(a / 625) == (a * Recip625) >> Recip625Shift for any a below 2^28
  localparam logic [26:0] Recip625      = 27'd109951163;
  localparam int unsigned Recip625Shift = 36;

  // scaled level width, saturation and floor
  localparam int unsigned LevelW  = 19;
  localparam logic [LevelW-1:0] LevelSat = 19'd65535;
  localparam logic [LevelW-1:0] LevelMin = 19'd2;

  localparam logic [3:0] ExpSat  = 4'd15;
  localparam logic [7:0] MantSat = 8'd255;

endpackage

// ===== rtl/voice_volume_log_encoder_top.sv =====
// volume log encoder: eight-stage pipeline from note velocity and volumes to exp/mantissa
// depends on vvle_pkg and voice_volume_log_encoder_top_macros.svh
//
//   channel  | direction | handshake                 | word
//   in       | sink      | in_valid_i / in_stall_o   | velocity, expression, patch_volume,
//            |           |                           | channel_main
//   out      | source    | out_valid_o / out_stall_i | volume_exponent, volume_mantissa
//   cfg      | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word per cycle sustained while the output is not stalled; an accepted word passes in order
// through eight stages to the output register, which is the last of them: level terms, two
// products, their sum, master volume product, partial products of the 1/10000 scaling,
// their sum with floor and ceiling, channel volume product, log encoder
// each stage advances when empty or when the next advances, so bubbles close up under stall
// reset clears the valid bits and loads master volume 60 and channel scaling off
`timescale 1ns / 1ps
`include "voice_volume_log_encoder_top_macros.svh"

module voice_volume_log_encoder_top
  import vvle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [6:0]          velocity_i,
  input  logic [6:0]          expression_i,
  input  logic [7:0]          patch_volume_i,
  input  logic [6:0]          channel_main_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          volume_exponent_o,
  output logic [7:0]          volume_mantissa_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [13:0] mv_sq_q;
  logic        use_main_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_sq_q    <= MasterVolSqReset;
      use_main_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MASTER_VOLUME:    mv_sq_q    <= 14'(cfg_data_i) * 14'(cfg_data_i);
        CFG_USE_CHANNEL_MAIN: use_main_q <= cfg_data_i[0];
        default:              ;
      endcase
    end
  end

  // stage valids and advance enables
  logic [8:1] v_q;
  logic [8:1] en;

  always_comb begin
    en[8] = !v_q[8] || !out_stall_i;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: level term, boosted expression, remapped channel volume
  logic signed [8:0]  dev;
  logic signed [8:0]  half_dev;
  logic signed [11:0] dev_l;
  logic signed [11:0] lvl_d;
  logic signed [9:0]  xpn_d;
  logic signed [11:0] lvl1_q;
  logic signed [9:0]  xpn1_q;
  logic [6:0]         vel1_q;
  logic [5:0]         pvq1_q;
  logic [6:0]         chv1_q;

  always_comb begin
    dev      = $signed({1'b0, patch_volume_i}) - 9'sd64;
    // halve, rounding toward zero
    half_dev = (dev + $signed({8'd0, dev[8]})) >>> 1;
    dev_l    = {{3{dev[8]}}, dev};
    lvl_d    = 12'sd256 + (dev_l <<< 2) + (dev_l <<< 1);
    xpn_d    = $signed({3'd0, expression_i}) + $signed({half_dev[8], half_dev});
    if (patch_volume_i > 8'd65) begin
      xpn_d = xpn_d + $signed({dev[8], dev});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      lvl1_q <= lvl_d;
      xpn1_q <= xpn_d;
      vel1_q <= velocity_i;
      pvq1_q <= patch_volume_i[7:2];
      chv1_q <= {1'b1, channel_main_i[6:1]};
    end
  end

  // stage 2: velocity times expression, quarter patch volume times level
  logic signed [17:0] t1_q;
  logic signed [18:0] t2_q;
  logic [13:0]        c2_2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      t1_q   <= $signed({1'b0, vel1_q}) * xpn1_q;
      t2_q   <= $signed({1'b0, pvq1_q}) * lvl1_q;
      c2_2_q <= 14'(chv1_q) * 14'(chv1_q);
    end
  end

  // stage 3: combined level
  logic signed [19:0] t1_e;
  logic signed [19:0] x_d;
  logic signed [19:0] x_q;
  logic [13:0]        c2_3_q;

  assign t1_e = {{2{t1_q[17]}}, t1_q};
  assign x_d  = (t1_e <<< 2) + (t1_e <<< 1) + {t2_q[18], t2_q};

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      x_q    <= x_d;
      c2_3_q <= c2_2_q;
    end
  end

  // stage 4: times master volume squared
  logic signed [34:0] p_q;
  logic [13:0]        c2_4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p_q    <= x_q * $signed({1'b0, mv_sq_q});
      c2_4_q <= c2_3_q;
    end
  end

  // stage 5: partial products of the reciprocal of 625 (the 16 is a shift)
  logic [40:0] ph_q;
  logic [40:0] pl_q;
  logic        neg5_q;
  logic        big5_q;
  logic [13:0] c2_5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ph_q   <= 41'(p_q[31:18]) * 41'(Recip625);
      pl_q   <= 41'(p_q[17:4]) * 41'(Recip625);
      neg5_q <= p_q[34];
      big5_q <= p_q[33] | p_q[32];
      c2_5_q <= c2_4_q;
    end
  end

  // stage 6: sum of partials gives level over 10000, with floor and ceiling
  logic [55:0]       sum6;
  logic [LevelW-1:0] q_d;
  logic [LevelW-1:0] q_q;
  logic [13:0]       c2_6_q;

  assign sum6 = 56'({ph_q, 14'd0}) + 56'(pl_q);

  always_comb begin
    if (neg5_q) begin
      q_d = '0;
    end else if (big5_q) begin
      // far above saturation whatever the channel volume
      q_d = '1;
    end else begin
      q_d = sum6[Recip625Shift+LevelW-1:Recip625Shift];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      q_q    <= q_d;
      c2_6_q <= c2_5_q;
    end
  end

  // stage 7: optional channel volume scaling
  logic [32:0]       r7;
  logic [LevelW-1:0] y_q;

  assign r7 = 33'(q_q) * 33'(c2_6_q);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      y_q <= use_main_q ? r7[32:14] : q_q;
    end
  end

  // stage 8: pseudo-log encoding into the output register
  logic [15:0] norm;
  logic [3:0]  lead;
  logic [3:0]  exp_d;
  logic [7:0]  mant_d;
  logic [3:0]  exp_q;
  logic [7:0]  mant_q;

  always_comb begin
    lead = '0;
    for (int i = 1; i < 16; i++) begin
      if (y_q[i]) lead = 4'(i);
    end
    norm = y_q[15:0] << (4'd15 - lead);
    if (y_q < LevelMin) begin
      exp_d  = '0;
      mant_d = '0;
    end else if (y_q >= LevelSat) begin
      exp_d  = ExpSat;
      mant_d = MantSat;
    end else begin
      exp_d  = lead;
      mant_d = norm[14:7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      exp_q  <= exp_d;
      mant_q <= mant_d;
    end
  end

  assign volume_exponent_o = exp_q;
  assign volume_mantissa_o = mant_q;

  // checks
  `VVLE_ASSERT_NXT(a_accept_fills, in_valid_i && en[1], v_q[1], "accepted word not in stage 1")
  `VVLE_ASSERT_NXT(a_neg_zero, en[6] && v_q[5] && neg5_q, q_q == '0, "negative level not floored")
  `VVLE_ASSERT_NXT(a_no_main_pass, en[7] && v_q[6] && !use_main_q, y_q == $past(q_q),
    "level changed with channel scaling off")
  `VVLE_ASSERT_IMP(a_zero_exp, out_valid_o && (volume_exponent_o == '0),
    volume_mantissa_o == '0, "zero exponent with non-zero mantissa")

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for voice_volume_log_encoder_top: directed and random volume words
// depends on vvle_pkg and the rtl of voice_volume_log_encoder_top
`timescale 1ns / 1ps

module tb_top;
  import vvle_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandPerSet  = 250;
  localparam int unsigned DrainCycles = 16;

  // one input word and one result word
  typedef struct packed {
    logic [6:0] velocity;
    logic [6:0] expression;
    logic [7:0] patch_volume;
    logic [6:0] channel_main;
  } volume_request_t;

  typedef struct packed {
    logic [3:0] exponent;
    logic [7:0] mantissa;
  } volume_word_t;

  // edge cases: field extremes, boost threshold, negative level, truncation, saturation
  localparam volume_request_t EdgeRequests [0:11] = '{
    '{7'd0,   7'd0,   8'd0,   7'd0},
    '{7'd127, 7'd127, 8'd255, 7'd127},
    '{7'd127, 7'd0,   8'd64,  7'd0},
    '{7'd64,  7'd64,  8'd65,  7'd64},
    '{7'd64,  7'd64,  8'd66,  7'd64},
    '{7'd100, 7'd100, 8'd63,  7'd100},
    '{7'd100, 7'd100, 8'd62,  7'd1},
    '{7'd0,   7'd0,   8'd1,   7'd0},
    '{7'd1,   7'd1,   8'd4,   7'd0},
    '{7'd3,   7'd5,   8'd64,  7'd2},
    '{7'd127, 7'd127, 8'd128, 7'd126},
    '{7'd20,  7'd30,  8'd200, 7'd127}
  };

  // expected volume words in acceptance order, with the current register copy
  class volume_scoreboard;
    volume_word_t pending_words[$];
    logic [6:0]   master_volume;
    logic         use_channel_main;
    int unsigned  errors;

    function new();
      master_volume    = 7'd60;
      use_channel_main = 1'b0;
      errors           = 0;
    endfunction

    function volume_word_t predict_volume_word(volume_request_t req);
      longint       vel, xpn, pv, chm, mv, lvl, acc, chan;
      int unsigned  v, e, m;
      volume_word_t w;
      vel = req.velocity;
      xpn = req.expression;
      pv  = req.patch_volume;
      chm = req.channel_main;
      mv  = master_volume;
      // level term and expression boost, signed division truncates toward zero
      lvl = 256 + 6 * (pv - 64);
      if (pv > 65) xpn += pv - 64;
      xpn += (pv - 64) / 2;
      acc = vel * xpn * 6 + (pv / 4) * lvl;
      acc = (acc * mv * mv) / 10000;
      if (use_channel_main) begin
        chan = chm / 2 + 64;
        acc  = (acc * chan * chan) / 16384;
      end
      // pseudo-log encoding
      if (acc < 2) begin
        w.exponent = 4'd0;
        w.mantissa = 8'd0;
      end else if (acc >= 65535) begin
        w.exponent = ExpSat;
        w.mantissa = MantSat;
      end else begin
        v = int'(acc);
        e = 0;
        while (e < 15 && (v >> (e + 1)) != 0) e++;
        m = v - (32'd1 << e);
        if (e > 8) m = m >> (e - 8);
        else if (e < 8) m = m << (8 - e);
        w.exponent = e[3:0];
        w.mantissa = m[7:0];
      end
      return w;
    endfunction

    function void note_request(volume_request_t req);
      pending_words.push_back(predict_volume_word(req));
    endfunction

    function void check_word(logic [3:0] exponent, logic [7:0] mantissa);
      volume_word_t exp_w;
      if (pending_words.size() == 0) begin
        $error("volume word with none expected: exponent %0d, mantissa %0d",
               exponent, mantissa);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (exponent !== exp_w.exponent) begin
        $error("volume_exponent: expected %0d, actual %0d", exp_w.exponent, exponent);
        errors++;
      end
      if (mantissa !== exp_w.mantissa) begin
        $error("volume_mantissa: expected %0d, actual %0d", exp_w.mantissa, mantissa);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [6:0]          velocity_i;
  logic [6:0]          expression_i;
  logic [7:0]          patch_volume_i;
  logic [6:0]          channel_main_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [3:0]          volume_exponent_o;
  logic [7:0]          volume_mantissa_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  volume_scoreboard sb;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      cycle_count;

  voice_volume_log_encoder_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .velocity_i        (velocity_i),
    .expression_i      (expression_i),
    .patch_volume_i    (patch_volume_i),
    .channel_main_i    (channel_main_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .volume_exponent_o (volume_exponent_o),
    .volume_mantissa_o (volume_mantissa_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // clock, 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // result side: random stall and checking of each accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_word(volume_exponent_o, volume_mantissa_o);
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("voice_volume_log_encoder_top test failed");
      $finish;
    end
  end

  function automatic volume_request_t rand_request();
    volume_request_t r;
    int unsigned     sel;
    r.velocity     = 7'($urandom_range(0, 127));
    r.expression   = 7'($urandom_range(0, 127));
    r.patch_volume = 8'($urandom_range(0, 255));
    r.channel_main = 7'($urandom_range(0, 127));
    sel = $urandom_range(0, 9);
    // bias some words towards neutral patch volume and small products
    if (sel < 2) begin
      r.patch_volume = 8'($urandom_range(56, 72));
    end else if (sel < 4) begin
      r.velocity   = 7'($urandom_range(0, 15));
      r.expression = 7'($urandom_range(0, 15));
    end
    return r;
  endfunction

  // present one word, with random idle cycles ahead of it
  task automatic send_word(volume_request_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    velocity_i     <= req.velocity;
    expression_i   <= req.expression;
    patch_volume_i <= req.patch_volume;
    channel_main_i <= req.channel_main;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MASTER_VOLUME) sb.master_volume = data;
    else sb.use_channel_main = data[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register settings per set of words, extremes included
  initial begin
    logic [6:0] set_mv  [0:5];
    logic       set_ucm [0:5];
    int unsigned i;
    int unsigned s;
    sb             = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    velocity_i     = '0;
    expression_i   = '0;
    patch_volume_i = '0;
    channel_main_i = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_MASTER_VOLUME;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    cycle_count    = 0;
    set_mv  = '{7'd100, 7'd127, 7'd0, 7'd60, 7'd1, 7'($urandom_range(0, 127))};
    set_ucm = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1))};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (s = 0; s < 6; s++) begin
      // idling: sender light and receiver heavy, then swapped, then none
      case (s / 2)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(CFG_MASTER_VOLUME, set_mv[s]);
      write_reg(CFG_USE_CHANNEL_MAIN, 7'(set_ucm[s]));
      if (s < 2) begin
        for (i = 0; i < 12; i++) send_word(EdgeRequests[i]);
      end
      for (i = 0; i < RandPerSet; i++) send_word(rand_request());
      in_valid_i <= 1'b0;
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("voice_volume_log_encoder_top test passed");
    end else begin
      $display("voice_volume_log_encoder_top test failed");
    end
    $finish;
  end

endmodule
